// ===== rtl/twdi_pkg.sv =====
// Shared constants, types and codes for the trie word document index.
// Used by the channel interfaces, the controller, the datapath and the top level.
package twdi_pkg;

  localparam int NODES       = 4096;
  localparam int SENTENCES   = 64;
  localparam int ALPHABET    = 26;

  localparam int NODE_W      = $clog2(NODES);
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int SLOT_W      = $clog2(CHILD_DEPTH);

  localparam int LETTER_W    = 5;
  localparam int SID_W       = 6;
  localparam int CNT_W       = 7;
  localparam int BITMAP_W    = 64;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CNT_W-1:0] SCOUNT_RESET = CNT_W'(64);

  // Selector codes of the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_SENTENCE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } twdi_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic walk;
    logic finish;
  } twdi_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last;
    logic out_free;
  } twdi_status_t;

endpackage

// ===== rtl/twdi_in_if.sv =====
// Input channel of the trie word document index: one letter of a word per transfer.
// Depends on twdi_pkg for the field widths.
interface twdi_in_if;
  import twdi_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [LETTER_W-1:0] letter;
  logic                last_letter;
  logic [SID_W-1:0]    sentence_id;

  modport source (output valid, func, letter, last_letter, sentence_id, input ready);
  modport sink   (input valid, func, letter, last_letter, sentence_id, output ready);
endinterface

// ===== rtl/twdi_out_if.sv =====
// Result channel of the trie word document index: one transfer per finished word.
// Depends on twdi_pkg for the field widths.
interface twdi_out_if;
  import twdi_pkg::*;

  logic                valid;
  logic                ready;
  logic                was_lookup;
  logic                word_found;
  logic [BITMAP_W-1:0] sentence_bitmap;
  logic                overflow;

  modport source (output valid, was_lookup, word_found, sentence_bitmap, overflow,
                  input ready);
  modport sink   (input valid, was_lookup, word_found, sentence_bitmap, overflow,
                  output ready);
endinterface

// ===== rtl/twdi_ctrl.sv =====
// Controller of the trie word document index: clearing pass, letter walk, word finish.
// Depends on twdi_pkg for the state, command and status types.
module twdi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  twdi_pkg::twdi_status_t stat,
  output twdi_pkg::twdi_cmd_t    cmd
);
  import twdi_pkg::*;

  twdi_state_t state;
  twdi_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        state_next = stat.last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // A walk step always follows the transfer of its letter.
  a_walk_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> $past(cmd.accept))
    else $error("walk step without an accepted letter");

  // A finished word waits while the result register is still occupied.
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !stat.out_free) |=> state == ST_FINISH)
    else $error("word finish left before the result register was free");

  // A letter that does not end its word returns straight to taking input.
  a_mid_word_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !stat.last) |=> state == ST_IDLE)
    else $error("mid-word letter did not return to idle");

endmodule

// ===== rtl/twdi_dp.sv =====
// Datapath of the trie word document index: child table, presence bitmaps, walk
// registers and the result register. Depends on twdi_pkg; driven by twdi_ctrl.
module twdi_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  twdi_pkg::twdi_cmd_t           cmd,
  output twdi_pkg::twdi_status_t        stat,
  input  logic                          func,
  input  logic [twdi_pkg::LETTER_W-1:0] letter,
  input  logic                          last_letter,
  input  logic [twdi_pkg::SID_W-1:0]    sentence_id,
  input  logic [twdi_pkg::CNT_W-1:0]    sentence_count,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_was_lookup,
  output logic                          out_word_found,
  output logic [twdi_pkg::BITMAP_W-1:0] out_sentence_bitmap,
  output logic                          out_overflow
);
  import twdi_pkg::*;

  logic [NODE_W-1:0]    child_mem [CHILD_DEPTH];
  logic [BITMAP_W-1:0]  pres_mem  [NODES];

  logic                 func_q;
  logic                 last_q;
  logic [SID_W-1:0]     sid_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [NODE_W-1:0]    child_q;
  logic [BITMAP_W-1:0]  pres_q;
  logic [NODE_W-1:0]    cur_node;
  logic                 missed;
  logic                 overflowed;
  logic [NODE_W-1:0]    nodes_used;
  logic [SLOT_W-1:0]    clr_addr;

  logic [LETTER_W-1:0]  letter_sat;
  logic [SLOT_W-1:0]    slot_addr;
  logic                 child_absent;
  logic [NODE_W-1:0]    node_next;
  logic                 missed_next;
  logic                 ovf_next;
  logic [NODE_W-1:0]    used_next;
  logic                 alloc;
  logic                 child_we;
  logic [SLOT_W-1:0]    child_addr;
  logic [NODE_W-1:0]    child_wdata;
  logic                 pres_we;
  logic [NODE_W-1:0]    pres_addr;
  logic [BITMAP_W-1:0]  pres_wdata;
  logic [BITMAP_W-1:0]  count_mask;

  // Letters past the alphabet fold onto its last letter.
  assign letter_sat = (letter >= LETTER_W'(ALPHABET)) ? LETTER_W'(ALPHABET - 1) : letter;
  assign slot_addr  = SLOT_W'(cur_node) * SLOT_W'(ALPHABET) + SLOT_W'(letter_sat);

  assign child_absent = (child_q == '0) || ({1'b0, child_q} >= (NODE_W + 1)'(NODES));

  always_comb begin
    node_next   = cur_node;
    missed_next = missed;
    ovf_next    = overflowed;
    used_next   = nodes_used;
    alloc       = 1'b0;
    if (func_q == FUNC_LOOKUP) begin
      if (!missed) begin
        if (child_absent) begin
          missed_next = 1'b1;
        end else begin
          node_next = child_q;
        end
      end
    end else if (!overflowed) begin
      if (child_absent) begin
        if (nodes_used < NODE_W'(NODES - 1)) begin
          alloc     = 1'b1;
          used_next = nodes_used + 1'b1;
          node_next = used_next;
        end else begin
          ovf_next = 1'b1;
        end
      end else begin
        node_next = child_q;
      end
    end
  end

  // Child table port: clearing sweep, new-node link on a walk, else a letter read.
  assign child_we    = cmd.clear || (cmd.walk && alloc);
  assign child_wdata = cmd.clear ? '0 : used_next;

  always_comb begin
    if (cmd.clear) begin
      child_addr = clr_addr;
    end else if (cmd.walk) begin
      child_addr = slot_q;
    end else begin
      child_addr = slot_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_addr] <= child_wdata;
    end else if (cmd.accept) begin
      child_q <= child_mem[child_addr];
    end
  end

  // Presence port: the walk reads the bitmap of the node it reaches, the finish of an
  // insert that has not overflowed writes it back with the sentence bit set.
  assign pres_we = (cmd.clear && clr_addr < SLOT_W'(NODES)) ||
                   (cmd.finish && func_q == FUNC_INSERT && !overflowed &&
                    {1'b0, sid_q} < (SID_W + 1)'(SENTENCES));
  assign pres_wdata = cmd.clear ? '0 : (pres_q | (BITMAP_W'(1) << sid_q));

  always_comb begin
    if (cmd.clear) begin
      pres_addr = clr_addr[NODE_W-1:0];
    end else if (cmd.finish) begin
      pres_addr = cur_node;
    end else begin
      pres_addr = node_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_addr] <= pres_wdata;
    end else if (cmd.walk) begin
      pres_q <= pres_mem[pres_addr];
    end
  end

  always_comb begin
    for (int i = 0; i < BITMAP_W; i++) begin
      count_mask[i] = (i < SENTENCES) && (CNT_W'(i) < sentence_count);
    end
  end

  // Item fields.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func;
      last_q <= last_letter;
      sid_q  <= sentence_id;
      slot_q <= slot_addr;
    end
  end

  // Walk state and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node   <= '0;
      missed     <= 1'b0;
      overflowed <= 1'b0;
      nodes_used <= '0;
      clr_addr   <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.walk) begin
        cur_node   <= node_next;
        missed     <= missed_next;
        overflowed <= ovf_next;
        nodes_used <= used_next;
      end else if (cmd.finish) begin
        cur_node   <= '0;
        missed     <= 1'b0;
        overflowed <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_was_lookup      <= func_q;
      out_word_found      <= (func_q == FUNC_LOOKUP) && !missed;
      out_sentence_bitmap <= ((func_q == FUNC_LOOKUP) && !missed) ? (pres_q & count_mask)
                                                                  : '0;
      out_overflow        <= (func_q == FUNC_INSERT) && overflowed;
    end
  end

  assign stat.clear_done = (clr_addr == SLOT_W'(CHILD_DEPTH - 1));
  assign stat.last       = last_q;
  assign stat.out_free   = !out_valid || out_ready;

  // Finishing a word returns the walk to the root and presents a result.
  a_finish_resets_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (cur_node == '0 && !missed && !overflowed && out_valid))
    else $error("word finish did not restore the walk state");

  // Each new node takes the next free number.
  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && alloc) |=> nodes_used == NODE_W'($past(nodes_used) + 1'b1))
    else $error("node allocation did not advance the node count by one");

  // A result is never written over one still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

endmodule

// ===== rtl/trie_word_document_index.sv =====
// Trie word document index. After reset the block first runs a clearing pass over all
// CHILD_DEPTH child-table entries (106496 at the default size, one entry per cycle, the
// presence bitmaps cleared alongside) during which it takes no letters; configuration
// writes are accepted throughout. Words then arrive one letter per transfer. A letter
// that does not end its word first reads the child table at the current node; then the
// step is decided and, for an insert that needs a new node, the link is written back.
// After a word's last letter a finish step forms the result and, for an insert that has
// not overflowed, writes the sentence bit into the node's bitmap; it waits while an
// earlier result still sits unaccepted in the output register. The single child-table
// port and the dependence of each letter on the node reached by the previous one let no
// new letter in before the last is through. Letters past 'z' count as 'z'. An insert
// that finds the node store full drops the rest of its word and reports overflow; nodes
// it already made stay. A lookup returns whether the word's path exists and its sentence
// bitmap masked to the low sentence_count bits. sentence_count is the only register, at
// byte address 0. Depends on twdi_pkg, twdi_in_if, twdi_out_if, twdi_ctrl and twdi_dp.
module trie_word_document_index (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twdi_pkg::APB_AW-1:0] paddr,
  input  logic [twdi_pkg::APB_DW-1:0] pwdata,
  output logic [twdi_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  twdi_in_if.sink                     item,
  twdi_out_if.source                  result
);
  import twdi_pkg::*;

  twdi_cmd_t        cmd;
  twdi_status_t     stat;
  logic [CNT_W-1:0] sentence_count;
  logic             cfg_write;

  // The register index is the word address; the low byte-address bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_count <= SCOUNT_RESET;
    end else if (cfg_write && paddr[2] == REG_SENTENCE_COUNT) begin
      sentence_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_SENTENCE_COUNT) begin
      prdata = {(APB_DW - CNT_W)'(0), sentence_count};
    end else begin
      prdata = '0;
    end
  end

  // The controller sequences the clearing pass and each letter's read, step and finish.
  twdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the trie, the walk state and the output register.
  twdi_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .func                (item.func),
    .letter              (item.letter),
    .last_letter         (item.last_letter),
    .sentence_id         (item.sentence_id),
    .sentence_count      (sentence_count),
    .out_ready           (result.ready),
    .out_valid           (result.valid),
    .out_was_lookup      (result.was_lookup),
    .out_word_found      (result.word_found),
    .out_sentence_bitmap (result.sentence_bitmap),
    .out_overflow        (result.overflow)
  );

endmodule
